@@ rtl/wta_hash_bin_max_pack_defines.svh @@
// Assertion macros used by the winner-take-all hash RTL.
`ifndef WTA_HASH_BIN_MAX_PACK_DEFINES_SVH
`define WTA_HASH_BIN_MAX_PACK_DEFINES_SVH

`ifndef ASSERT_OFF
`define WTA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WTA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define WTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/wta_pkg.sv @@
// Types and constants of the winner-take-all hash block.
package wta_pkg;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_ELEM   = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] CFG_HASHES_PER_TABLE = 2'd0;
    localparam logic [1:0] CFG_TABLE_COUNT      = 2'd1;
    localparam logic [1:0] CFG_FIELD_SHIFT      = 2'd2;
    localparam logic [1:0] CFG_PERM_COUNT       = 2'd3;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         perm_number;
        logic [9:0]         dim_index;
        logic [11:0]        bin_id;
        logic [15:0]        bin_position;
        logic signed [31:0] sample_value;
    } item_t;

    typedef struct packed {
        logic [31:0] hash_value;
        logic [3:0]  table_number;
        logic        overflowed;
        logic        last;
    } hash_t;

    typedef struct packed {
        logic [11:0] bin_id;
        logic [15:0] position;
    } table_entry_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [9:0]         dim;
    } elem_entry_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [15:0]        position;
    } bin_entry_t;

endpackage

@@ rtl/wta_hash_bin_max_pack.sv @@
// Top level of the winner-take-all hash block.
// Load and element transfers are taken one per cycle while the block is idle. A finish
// transfer first clears min(K*L, MAX_BINS) entries of the bin memory, one per cycle, then
// walks every buffered element of every permutation (element read, table read, bin read,
// compare and write back through the bin memory), and finally builds each of the L hashes
// from K bin reads and accumulations before presenting it; the next hash starts once the
// current one has been transferred, and new items are accepted after the last one.
`include "wta_hash_bin_max_pack_defines.svh"

module wta_hash_bin_max_pack #(
    parameter int MAX_DIM      = 1024,
    parameter int MAX_PERMS    = 8,
    parameter int MAX_ELEMENTS = 1024,
    parameter int MAX_BINS     = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  wta_pkg::item_t item,
    output logic           hash_valid,
    input  logic           hash_stall,
    output wta_pkg::hash_t hash,
    input  logic           cfg_write,
    input  logic [1:0]     cfg_index,
    input  logic [4:0]     cfg_data
);

    localparam int TDEPTH = MAX_PERMS * MAX_DIM;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int EAW    = $clog2(MAX_ELEMENTS);
    localparam int ECW    = $clog2(MAX_ELEMENTS + 1);
    localparam int BAW    = $clog2(MAX_BINS);
    localparam int PW     = $clog2(MAX_PERMS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_ELEM, S_TAB, S_BIN, S_UPD, S_ERD, S_EACC, S_OUT
    } state_t;

    state_t state_reg;

    logic [4:0] k_cfg_reg, l_cfg_reg, shift_cfg_reg;
    logic [3:0] perm_cfg_reg;

    logic [ECW-1:0] count_reg, e_reg;
    logic           overflow_reg;
    logic [PW-1:0]  p_reg;
    logic [8:0]     cnt_reg;
    logic signed [31:0] val_reg;
    logic [11:0]    bin_reg;
    logic [15:0]    pos_reg;
    logic [4:0]     k_reg, l_reg;
    logic [8:0]     j_reg;
    logic [9:0]     sh_reg;
    logic [31:0]    acc_reg;
    logic           hash_valid_reg;
    wta_pkg::hash_t hash_reg;

    logic [4:0]  k_eff, l_eff;
    logic [9:0]  nbins;
    logic [PW-1:0] perms;
    logic        accept;
    logic        hash_done;

    logic                  tab_we;
    logic [TAW-1:0]        tab_waddr, tab_raddr;
    wta_pkg::table_entry_t tab_wdata, tab_rdata;
    logic                  elem_we;
    logic [EAW-1:0]        elem_waddr, elem_raddr;
    wta_pkg::elem_entry_t  elem_wdata, elem_rdata;
    logic                  bin_we;
    logic [BAW-1:0]        bin_waddr, bin_raddr;
    wta_pkg::bin_entry_t   bin_wdata, bin_rdata;

    logic        e_last, p_last, bin_ok, dim_ok;
    logic [31:0] term, acc_sum;

    assign k_eff = (k_cfg_reg == 5'd0) ? 5'd1 : ((k_cfg_reg > 5'd16) ? 5'd16 : k_cfg_reg);
    assign l_eff = (l_cfg_reg == 5'd0) ? 5'd1 : ((l_cfg_reg > 5'd16) ? 5'd16 : l_cfg_reg);
    assign nbins = 10'(k_eff) * 10'(l_eff);
    assign perms = (32'(perm_cfg_reg) > MAX_PERMS) ? PW'(MAX_PERMS) : PW'(perm_cfg_reg);

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign hash_valid = hash_valid_reg;
    assign hash       = hash_reg;
    assign hash_done  = hash_valid && !hash_stall && hash.last;

    assign e_last = (ECW'(e_reg + 1'b1) == count_reg);
    assign p_last = (PW'(p_reg + 1'b1) == perms);
    assign dim_ok = (32'(elem_rdata.dim) < MAX_DIM);
    assign bin_ok = (tab_rdata.bin_id < 12'(nbins)) && (32'(tab_rdata.bin_id) < MAX_BINS);

    assign term    = (32'(j_reg) < MAX_BINS) ? 32'(bin_rdata.position) : 32'd0;
    assign acc_sum = (sh_reg < 10'd32) ? (acc_reg + (term << sh_reg[4:0])) : acc_reg;

    always_comb
    begin
        tab_we     = accept && (item.func == wta_pkg::FUNC_LOAD)
                     && (32'(item.perm_number) < MAX_PERMS) && (32'(item.dim_index) < MAX_DIM);
        tab_waddr  = TAW'(32'(item.perm_number) * MAX_DIM + 32'(item.dim_index));
        tab_wdata  = '{bin_id: item.bin_id, position: item.bin_position};
        tab_raddr  = TAW'(32'(p_reg) * MAX_DIM + 32'(elem_rdata.dim));

        elem_we    = accept && (item.func == wta_pkg::FUNC_ELEM)
                     && (32'(count_reg) < MAX_ELEMENTS);
        elem_waddr = EAW'(count_reg);
        elem_wdata = '{value: item.sample_value, dim: item.dim_index};
        elem_raddr = EAW'(e_reg);

        bin_we     = 1'b0;
        bin_waddr  = BAW'(cnt_reg);
        bin_wdata  = '{value: wta_pkg::INT_MIN, position: 16'd0};
        bin_raddr  = BAW'(j_reg);
        unique case (state_reg)
            S_CLEAR:
            begin
                bin_we = 1'b1;
            end
            S_BIN:
            begin
                bin_raddr = BAW'(tab_rdata.bin_id);
            end
            S_UPD:
            begin
                bin_waddr = BAW'(bin_reg);
                bin_wdata = '{value: val_reg, position: pos_reg};
                bin_we    = (val_reg > bin_rdata.value);
            end
            default:
            begin
            end
        endcase
    end

    wta_ram #(.WIDTH($bits(wta_pkg::table_entry_t)), .DEPTH(TDEPTH)) u_table (
        .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
        .raddr(tab_raddr), .rdata(tab_rdata)
    );

    wta_ram #(.WIDTH($bits(wta_pkg::elem_entry_t)), .DEPTH(MAX_ELEMENTS)) u_elem (
        .clk(clk), .we(elem_we), .waddr(elem_waddr), .wdata(elem_wdata),
        .raddr(elem_raddr), .rdata(elem_rdata)
    );

    wta_ram #(.WIDTH($bits(wta_pkg::bin_entry_t)), .DEPTH(MAX_BINS)) u_bins (
        .clk(clk), .we(bin_we), .waddr(bin_waddr), .wdata(bin_wdata),
        .raddr(bin_raddr), .rdata(bin_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_cfg_reg      <= 5'd1;
            l_cfg_reg      <= 5'd1;
            shift_cfg_reg  <= 5'd0;
            perm_cfg_reg   <= 4'd1;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            hash_valid_reg <= 1'b0;
            e_reg          <= '0;
            p_reg          <= '0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            l_reg          <= '0;
            j_reg          <= '0;
            sh_reg         <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    wta_pkg::CFG_HASHES_PER_TABLE: k_cfg_reg     <= cfg_data;
                    wta_pkg::CFG_TABLE_COUNT:      l_cfg_reg     <= cfg_data;
                    wta_pkg::CFG_FIELD_SHIFT:      shift_cfg_reg <= cfg_data;
                    wta_pkg::CFG_PERM_COUNT:       perm_cfg_reg  <= cfg_data[3:0];
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.func == wta_pkg::FUNC_ELEM)
                        begin
                            if (32'(count_reg) < MAX_ELEMENTS)
                            begin
                                count_reg <= ECW'(count_reg + 1'b1);
                            end
                            else
                            begin
                                overflow_reg <= 1'b1;
                            end
                        end
                        else if (item.func == wta_pkg::FUNC_FINISH)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR:
                begin
                    cnt_reg <= 9'(cnt_reg + 1'b1);
                    if ((10'(cnt_reg) + 10'd1 >= nbins) || (32'(cnt_reg) + 1 >= MAX_BINS))
                    begin
                        e_reg   <= '0;
                        p_reg   <= '0;
                        l_reg   <= '0;
                        k_reg   <= '0;
                        j_reg   <= '0;
                        sh_reg  <= '0;
                        acc_reg <= '0;
                        if ((perms == '0) || (count_reg == '0))
                        begin
                            state_reg <= S_ERD;
                        end
                        else
                        begin
                            state_reg <= S_ELEM;
                        end
                    end
                end
                S_ELEM:
                begin
                    state_reg <= S_TAB;
                end
                S_TAB, S_BIN, S_UPD:
                begin
                    val_reg <= (state_reg == S_TAB) ? elem_rdata.value : val_reg;
                    if (state_reg == S_BIN)
                    begin
                        bin_reg <= tab_rdata.bin_id;
                        pos_reg <= tab_rdata.position;
                    end
                    if ((state_reg == S_TAB) && dim_ok)
                    begin
                        state_reg <= S_BIN;
                    end
                    else if ((state_reg == S_BIN) && bin_ok)
                    begin
                        state_reg <= S_UPD;
                    end
                    else if (!e_last)
                    begin
                        e_reg     <= ECW'(e_reg + 1'b1);
                        state_reg <= S_ELEM;
                    end
                    else if (!p_last)
                    begin
                        e_reg     <= '0;
                        p_reg     <= PW'(p_reg + 1'b1);
                        state_reg <= S_ELEM;
                    end
                    else
                    begin
                        state_reg <= S_ERD;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_EACC;
                end
                S_EACC:
                begin
                    j_reg  <= 9'(j_reg + 1'b1);
                    k_reg  <= 5'(k_reg + 1'b1);
                    sh_reg <= 10'(sh_reg + 10'(shift_cfg_reg));
                    acc_reg <= acc_sum;
                    if (5'(k_reg + 1'b1) == k_eff)
                    begin
                        hash_reg.hash_value   <= acc_sum;
                        hash_reg.table_number <= l_reg[3:0];
                        hash_reg.overflowed   <= overflow_reg;
                        hash_reg.last         <= (5'(l_reg + 1'b1) == l_eff);
                        hash_valid_reg        <= 1'b1;
                        state_reg             <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_ERD;
                    end
                end
                S_OUT:
                begin
                    if (!hash_stall)
                    begin
                        hash_valid_reg <= 1'b0;
                        k_reg          <= '0;
                        sh_reg         <= '0;
                        acc_reg        <= '0;
                        l_reg          <= 5'(l_reg + 1'b1);
                        if (hash_reg.last)
                        begin
                            count_reg    <= '0;
                            overflow_reg <= 1'b0;
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_ERD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `WTA_ASSERT_IMPLY(a_bin_write_in_range, clk, rst_n, bin_we, 10'(bin_waddr) < nbins)
    `WTA_ASSERT_NEXT(a_last_ends_sample, clk, rst_n, hash_done, !hash_valid && count_reg == '0)
    `WTA_ASSERT_IMPLY(a_count_bounded, clk, rst_n, 1'b1, 32'(count_reg) <= MAX_ELEMENTS)

endmodule

@@ rtl/wta_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
